>>> rtl/scm_pkg.sv
// ----------------------------------------------------------------------------
// Scan curvature and occlusion marker: shared package
// Types, register indexes, reset values and window constants used by the
// front, the queue and the back of the marker.
// ----------------------------------------------------------------------------
package scm_pkg;

  // Field widths fixed by the point and result formats.
  localparam int unsigned RANGE_W = 16;
  localparam int unsigned COL_W   = 11;
  localparam int unsigned OIDX_W  = 15;
  localparam int unsigned CURV_W  = 39;
  // Sum of eleven ranges and its magnitude after the centre is taken off.
  localparam int unsigned SUM_W   = 20;
  // Queue entries carry the scan position at the widest counter allowed.
  localparam int unsigned IDX_W   = 16;
  localparam int unsigned SEEN_W  = 5;
  localparam int unsigned MARKS   = 7;

  // Default sizes of the scan.
  localparam int unsigned MAX_POINTS_DEF = 32768;
  localparam int unsigned COLUMNS_DEF    = 2048;

  // Window geometry.
  localparam int unsigned RWIN_DEPTH = 11;
  localparam logic [2:0] LAG        = 3'd6;
  localparam logic [2:0] HALF       = 3'd5;
  localparam logic [2:0] FWD_MARKS  = 3'd5;
  localparam logic [SEEN_W-1:0] SEEN_CAP    = 5'd16;
  localparam logic [SEEN_W-1:0] SEEN_PAIRS  = 5'd7;
  localparam logic [SEEN_W-1:0] SEEN_VALID6 = 5'd12;
  localparam logic [SEEN_W-1:0] SEEN_VALID5 = 5'd11;

  // Depth of the queue between front and back.
  localparam int unsigned QDEPTH = 4;

  // Configuration register indexes.
  localparam logic [1:0] REG_OCC_GAP    = 2'd0;
  localparam logic [1:0] REG_BEAM_RATIO = 2'd1;
  localparam logic [1:0] REG_COL_GAP    = 2'd2;

  // Configuration reset values.
  localparam logic [15:0] OCC_GAP_RST    = 16'd300;
  localparam logic [9:0]  BEAM_RATIO_RST = 10'd20;
  localparam logic [10:0] COL_GAP_RST    = 11'd10;

  // One input word: a point of the scan.
  typedef struct packed {
    logic [RANGE_W-1:0] range_mm;
    logic [COL_W-1:0]   column;
    logic               last_point;
  } in_word_t;

  // One output word: the score and flags of a point.
  typedef struct packed {
    logic [OIDX_W-1:0] point_index;
    logic [CURV_W-1:0] curvature;
    logic              curvature_valid;
    logic              unreliable;
    logic              last_result;
  } out_word_t;

  // One queue entry: everything the back needs to emit the results of a word.
  typedef struct packed {
    logic               flush;
    logic [SEEN_W-1:0]  seen;
    logic [IDX_W-1:0]   newest;
    logic [MARKS-1:0]   marks;
    logic [SUM_W-1:0]   sum5;
    logic [RANGE_W-1:0] r5;
    logic [SUM_W-1:0]   sum6;
    logic [RANGE_W-1:0] r6;
  } entry_t;

  // Queue status seen by both sides.
  typedef struct packed {
    logic full;
    logic nonempty;
  } qstat_t;

endpackage

>>> rtl/scm_queue.sv
// ----------------------------------------------------------------------------
// Scan curvature and occlusion marker: entry queue
// A short first-in first-out store of entries between the front and the back.
// ----------------------------------------------------------------------------
module scm_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  scm_pkg::entry_t push_entry,
  input  logic            pop,
  output scm_pkg::entry_t head_entry,
  output scm_pkg::qstat_t stat
);

  localparam int unsigned PTR_W = $clog2(scm_pkg::QDEPTH);
  localparam int unsigned CNT_W = $clog2(scm_pkg::QDEPTH + 1);

  scm_pkg::entry_t  store_r [scm_pkg::QDEPTH];
  logic [PTR_W-1:0] wptr_r;
  logic [PTR_W-1:0] rptr_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;

  // Status from the fill count.
  always_comb begin
    stat.full     = (count_r == CNT_W'(scm_pkg::QDEPTH));
    stat.nonempty = (count_r != '0);
    head_entry    = store_r[rptr_r];
  end

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wptr_r <= (wptr_r == PTR_W'(scm_pkg::QDEPTH - 1)) ? '0 : wptr_r + 1'b1;
      end
      if (pop) begin
        rptr_r <= (rptr_r == PTR_W'(scm_pkg::QDEPTH - 1)) ? '0 : rptr_r + 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      store_r[wptr_r] <= push_entry;
    end
  end

  // The queue is never written when full nor read when empty.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    stat.full && !pop |-> !push)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> stat.nonempty)
    else $error("queue read while empty");
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> count_r == $past(count_r) + 1'b1)
    else $error("fill count did not follow a push");

endmodule

>>> rtl/scm_front.sv
// ----------------------------------------------------------------------------
// Scan curvature and occlusion marker: front
// Takes points, keeps the range window, running sum and marks, applies the
// occlusion and parallel beam rules, and queues an entry per releasing point.
// ----------------------------------------------------------------------------
module scm_front #(
  parameter int unsigned MAX_POINTS = scm_pkg::MAX_POINTS_DEF,
  parameter int unsigned COLUMNS    = scm_pkg::COLUMNS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_idx,
  input  logic [15:0]       cfg_wdata,
  input  logic              in_valid,
  output logic              in_ready,
  input  scm_pkg::in_word_t in_word,
  input  scm_pkg::qstat_t   q_stat,
  output logic              push,
  output scm_pkg::entry_t   push_entry
);

  localparam int unsigned PW = $clog2(MAX_POINTS);
  localparam int unsigned RW = scm_pkg::RANGE_W;
  localparam int unsigned CW = scm_pkg::COL_W;
  localparam int unsigned LIM_W = 26;

  // Configuration.
  logic [15:0]  occ_gap_r;
  logic [9:0]   beam_r;
  logic [10:0]  col_gap_r;

  // Scan state.
  logic [RW-1:0]                  rwin_r [scm_pkg::RWIN_DEPTH];
  logic [CW-1:0]                  col0_r;
  logic [scm_pkg::MARKS-1:0]      mark_r;
  logic [scm_pkg::SUM_W-1:0]      sum_r;
  logic [scm_pkg::SEEN_W-1:0]     seen_r;
  logic [2:0]                     fwd_r;
  logic [PW-1:0]                  pcount_r;

  logic [scm_pkg::MARKS-1:0]      mark_nxt;
  logic [scm_pkg::SUM_W-1:0]      sum_nxt;
  logic [scm_pkg::SEEN_W-1:0]     seen_nxt;
  logic [2:0]                     fwd_nxt;
  logic [PW-1:0]                  pcount_nxt;

  logic          accept;
  logic [RW-1:0] r_in;
  logic [CW-1:0] c_in;
  logic [CW-1:0] col_diff;
  logic [RW-1:0] d10;
  logic [RW-1:0] d21;
  logic [LIM_W-1:0] beam_lim;
  logic          pair_on;

  // Handshake: the front stalls only on a full queue.
  always_comb begin
    in_ready = !q_stat.full;
    accept   = in_valid && in_ready;
    push     = accept && (in_word.last_point || (seen_nxt >= scm_pkg::SEEN_PAIRS));
  end

  // Input word, with the column held inside the image.
  always_comb begin
    r_in = in_word.range_mm;
    c_in = in_word.column;
    if (32'(in_word.column) >= COLUMNS) begin
      c_in = CW'(COLUMNS - 1);
    end
  end

  // Counters and running sum of the eleven newest ranges.
  always_comb begin
    seen_nxt   = (seen_r < scm_pkg::SEEN_CAP) ? seen_r + 1'b1 : seen_r;
    pcount_nxt = (pcount_r == PW'(MAX_POINTS - 1)) ? '0 : pcount_r + 1'b1;
    sum_nxt    = sum_r + scm_pkg::SUM_W'(r_in)
                 - scm_pkg::SUM_W'(rwin_r[scm_pkg::RWIN_DEPTH-1]);
  end

  // Differences for the pair and beam tests.
  always_comb begin
    col_diff = (c_in > col0_r) ? c_in - col0_r : col0_r - c_in;
    d10      = (rwin_r[0] > r_in) ? rwin_r[0] - r_in : r_in - rwin_r[0];
    d21      = (rwin_r[1] > rwin_r[0]) ? rwin_r[1] - rwin_r[0] : rwin_r[0] - rwin_r[1];
    beam_lim = LIM_W'(beam_r) * LIM_W'(rwin_r[0]);
    pair_on  = (seen_nxt >= scm_pkg::SEEN_PAIRS);
  end

  // Marks after shifting in the new point and applying both rules.
  always_comb begin
    mark_nxt    = {mark_r[scm_pkg::MARKS-2:0], (fwd_r != 3'd0)};
    fwd_nxt     = (fwd_r != 3'd0) ? fwd_r - 1'b1 : fwd_r;
    if (pair_on) begin
      if (col_diff < col_gap_r) begin
        if ((rwin_r[0] > r_in) && (d10 > occ_gap_r)) begin
          // Nearer point ahead: the six points behind it are hidden.
          mark_nxt[scm_pkg::MARKS-1:1] = '1;
        end else if ((r_in > rwin_r[0]) && (d10 > occ_gap_r)) begin
          // Nearer point behind: this one and the next five are hidden.
          mark_nxt[0] = 1'b1;
          fwd_nxt     = scm_pkg::FWD_MARKS;
        end
      end
      if (({d21, 10'b0} > beam_lim) && ({d10, 10'b0} > beam_lim)) begin
        mark_nxt[1] = 1'b1;
      end
    end
  end

  // Entry for the back.
  always_comb begin
    push_entry.flush  = in_word.last_point;
    push_entry.seen   = seen_nxt;
    push_entry.newest = scm_pkg::IDX_W'(pcount_r);
    push_entry.marks  = mark_nxt;
    push_entry.sum5   = sum_nxt;
    push_entry.r5     = rwin_r[4];
    push_entry.sum6   = sum_r;
    push_entry.r6     = rwin_r[5];
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_gap_r <= scm_pkg::OCC_GAP_RST;
      beam_r    <= scm_pkg::BEAM_RATIO_RST;
      col_gap_r <= scm_pkg::COL_GAP_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        scm_pkg::REG_OCC_GAP:    occ_gap_r <= cfg_wdata;
        scm_pkg::REG_BEAM_RATIO: beam_r    <= cfg_wdata[9:0];
        scm_pkg::REG_COL_GAP:    col_gap_r <= cfg_wdata[10:0];
        default: ;
      endcase
    end
  end

  // Scan state: shifted on each word, cleared after the last point.
  always_ff @(posedge clk) begin
    if (!rst_n || (accept && in_word.last_point)) begin
      for (int k = 0; k < scm_pkg::RWIN_DEPTH; k++) begin
        rwin_r[k] <= '0;
      end
      col0_r   <= '0;
      mark_r   <= '0;
      sum_r    <= '0;
      seen_r   <= '0;
      fwd_r    <= '0;
      pcount_r <= '0;
    end else if (accept) begin
      rwin_r[0] <= r_in;
      for (int k = 1; k < scm_pkg::RWIN_DEPTH; k++) begin
        rwin_r[k] <= rwin_r[k-1];
      end
      col0_r   <= c_in;
      mark_r   <= mark_nxt;
      sum_r    <= sum_nxt;
      seen_r   <= seen_nxt;
      fwd_r    <= fwd_nxt;
      pcount_r <= pcount_nxt;
    end
  end

endmodule

>>> rtl/scm_back.sv
// ----------------------------------------------------------------------------
// Scan curvature and occlusion marker: back
// Expands queue entries into results, one a cycle while taken, via a magnitude
// stage and a squaring stage that also serves as the output register.
// ----------------------------------------------------------------------------
module scm_back #(
  parameter int unsigned MAX_POINTS = scm_pkg::MAX_POINTS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  scm_pkg::entry_t    head_entry,
  input  scm_pkg::qstat_t    q_stat,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output scm_pkg::out_word_t out_word
);

  localparam int unsigned PW = $clog2(MAX_POINTS);
  localparam int unsigned SW = scm_pkg::SUM_W;

  logic [2:0]  cnt_r;
  logic [2:0]  cnt_nxt;
  logic [2:0]  jmax;
  logic [2:0]  jpos;
  logic        issue;
  logic        entry_done;
  logic        cv;
  logic [PW-1:0] newest;
  logic [PW:0]   wrapped;
  logic [PW-1:0] pidx;
  logic [SW-1:0] sum_sel;
  logic [SW-1:0] r11;
  logic [SW-1:0] mag;

  // Magnitude stage.
  logic                       s1_valid_r;
  logic [scm_pkg::OIDX_W-1:0] s1_idx_r;
  logic [SW-1:0]              s1_mag_r;
  logic                       s1_cv_r;
  logic                       s1_unrel_r;
  logic                       s1_last_r;

  // Output stage.
  logic                s2_valid_r;
  scm_pkg::out_word_t  s2_word_r;

  logic s1_load;
  logic s2_load;

  // Stage flow: each stage moves when the one after it has room.
  always_comb begin
    s2_load = !s2_valid_r || out_ready;
    s1_load = !s1_valid_r || s2_load;
    issue   = q_stat.nonempty && s1_load;
  end

  // Position in the window of the result now being issued.
  always_comb begin
    jmax = (head_entry.seen > scm_pkg::SEEN_PAIRS) ? scm_pkg::LAG
           : 3'(head_entry.seen - 1'b1);
    jpos       = head_entry.flush ? jmax - cnt_r : scm_pkg::LAG;
    entry_done = !head_entry.flush || (jpos == 3'd0);
    pop        = issue && entry_done;
    cnt_nxt    = pop ? 3'd0 : (issue ? cnt_r + 1'b1 : cnt_r);
  end

  // Curvature is only defined with five neighbours on each side.
  always_comb begin
    cv = ((jpos == scm_pkg::LAG) && (head_entry.seen >= scm_pkg::SEEN_VALID6)) ||
         (head_entry.flush && (jpos == scm_pkg::HALF) &&
          (head_entry.seen >= scm_pkg::SEEN_VALID5));
  end

  // Scan position of the point, wrapping at the scan length.
  always_comb begin
    newest  = head_entry.newest[PW-1:0];
    wrapped = {1'b0, newest} + (PW+1)'(MAX_POINTS) - (PW+1)'(jpos);
    pidx    = (newest >= PW'(jpos)) ? newest - PW'(jpos) : wrapped[PW-1:0];
  end

  // Neighbour sum less ten times the centre, as eleven-point sum less 11r.
  always_comb begin
    if (jpos == scm_pkg::LAG) begin
      sum_sel = head_entry.sum6;
      r11     = (SW'(head_entry.r6) << 3) + (SW'(head_entry.r6) << 1) + SW'(head_entry.r6);
    end else begin
      sum_sel = head_entry.sum5;
      r11     = (SW'(head_entry.r5) << 3) + (SW'(head_entry.r5) << 1) + SW'(head_entry.r5);
    end
    mag = (sum_sel >= r11) ? sum_sel - r11 : r11 - sum_sel;
    if (!cv) begin
      mag = '0;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (s1_load) begin
        s1_valid_r <= issue;
      end
      if (s2_load) begin
        s2_valid_r <= s1_valid_r;
      end
    end
  end

  // Magnitude stage payload.
  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_idx_r   <= scm_pkg::OIDX_W'(pidx);
      s1_mag_r   <= mag;
      s1_cv_r    <= cv;
      s1_unrel_r <= head_entry.marks[jpos];
      s1_last_r  <= head_entry.flush && (jpos == 3'd0);
    end
  end

  // Squaring stage payload.
  always_ff @(posedge clk) begin
    if (s2_load) begin
      s2_word_r.point_index     <= s1_idx_r;
      s2_word_r.curvature       <= scm_pkg::CURV_W'((2*SW)'(s1_mag_r) * (2*SW)'(s1_mag_r));
      s2_word_r.curvature_valid <= s1_cv_r;
      s2_word_r.unreliable      <= s1_unrel_r;
      s2_word_r.last_result     <= s1_last_r;
    end
  end

  always_comb begin
    out_valid = s2_valid_r;
    out_word  = s2_word_r;
  end

  // A word whose curvature is not valid carries a zero score.
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_word.curvature_valid |-> out_word.curvature == '0)
    else $error("invalid curvature is not zero");
  // The last result of a scan closes its queue entry.
  a_last_pops: assert property (@(posedge clk) disable iff (!rst_n)
    issue && head_entry.flush && (jpos == 3'd0) |-> pop)
    else $error("last result issued without closing its entry");
  // A flush never issues more than seven results.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= scm_pkg::LAG)
    else $error("result counter beyond the window");
  // A stalled magnitude stage keeps its word.
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s2_load |=> s1_valid_r && $stable(s1_mag_r))
    else $error("magnitude stage lost a word under stall");

endmodule

>>> rtl/scan_curvature_and_occlusion_marker.sv
// ----------------------------------------------------------------------------
// Scan curvature and occlusion marker: top level
// Streams one lidar scan's points and returns a curvature score and an
// unreliable flag for each point, six points behind the input.
// ----------------------------------------------------------------------------
// The block takes one point per clock cycle while its results are taken every
// cycle. A point's result is released by the sixth point after it and goes
// through the queue, the magnitude stage and the output register; the last
// point of a scan flushes every point still held, up to seven results, from a
// single queue entry. The back issues one result per cycle while its output is
// taken; a scan ending adds up to six extra results. The four-entry queue
// holds that flush entry and three more behind it, so the front keeps taking
// points while it drains unless more than three further entries arrive first,
// as when very short scans follow one another; the input then stalls until the
// back catches up. Points within five of either end of the scan report
// curvature 0 with curvature_valid low. No clearing pass is needed after reset.
// Configuration is written through cfg_we, cfg_idx and cfg_wdata between
// scans or while the block is idle.
// ----------------------------------------------------------------------------
module scan_curvature_and_occlusion_marker #(
  parameter int unsigned MAX_POINTS = scm_pkg::MAX_POINTS_DEF,
  parameter int unsigned COLUMNS    = scm_pkg::COLUMNS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_idx,
  input  logic [15:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  scm_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_ready,
  output scm_pkg::out_word_t out_word
);

  scm_pkg::entry_t push_entry;
  scm_pkg::entry_t head_entry;
  scm_pkg::qstat_t q_stat;
  logic            push;
  logic            pop;

  // Front: window, rules and entry building.
  scm_front #(
    .MAX_POINTS (MAX_POINTS),
    .COLUMNS    (COLUMNS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_word    (in_word),
    .q_stat     (q_stat),
    .push       (push),
    .push_entry (push_entry)
  );

  // Queue between the two sides.
  scm_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head_entry (head_entry),
    .stat       (q_stat)
  );

  // Back: scoring and output.
  scm_back #(
    .MAX_POINTS (MAX_POINTS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_entry (head_entry),
    .q_stat     (q_stat),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_word   (out_word)
  );

endmodule

>>> sim/tb_scan_curvature_and_occlusion_marker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Scan curvature and occlusion marker: testbench
// Streams scans of points through the marker and checks every result word
// against a scoring model kept in the bench. A short directed table covers
// field extremes, the smallest scan and both occlusion directions. Random
// scans follow under several register settings, with a long result stall and
// a scan at full rate on both sides. Both sides idle at random.
// ----------------------------------------------------------------------------
module tb_scan_curvature_and_occlusion_marker;

  localparam int unsigned CYC_LIMIT = 1000000;
  localparam int unsigned LONG_HOLD = 300;
  localparam int unsigned SETTLE    = 12;
  localparam int unsigned DIR_ROWS  = 27;

  localparam logic [15:0] RMAX     = 16'hFFFF;
  localparam logic [10:0] CMAX     = 11'h7FF;
  localparam logic [38:0] CURV_MAX = 39'd429483622500;

  // One row of the directed table: a point and, where typed in, the first
  // result word that the point releases.
  typedef struct packed {
    scm_pkg::in_word_t  pt;
    logic               typed;
    scm_pkg::out_word_t res;
  } dir_row_t;

  // Scan one: full-range points around a zero-range point, columns far apart.
  // Scan two: a single point. Scan three: a step up and a step down between
  // neighbouring columns, so that both occlusion directions fire.
  localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
    '{'{RMAX, 11'd0, 1'b0}, 1'b0, '0},
    '{'{RMAX, CMAX,  1'b0}, 1'b0, '0},
    '{'{RMAX, 11'd0, 1'b0}, 1'b0, '0},
    '{'{RMAX, CMAX,  1'b0}, 1'b0, '0},
    '{'{RMAX, 11'd0, 1'b0}, 1'b0, '0},
    '{'{16'd0, CMAX, 1'b0}, 1'b0, '0},
    '{'{RMAX, 11'd0, 1'b0}, 1'b1, '{15'd0, 39'd0, 1'b0, 1'b0, 1'b0}},
    '{'{RMAX, CMAX,  1'b0}, 1'b0, '0},
    '{'{RMAX, 11'd0, 1'b0}, 1'b0, '0},
    '{'{RMAX, CMAX,  1'b0}, 1'b0, '0},
    '{'{RMAX, 11'd0, 1'b0}, 1'b0, '0},
    '{'{RMAX, CMAX,  1'b1}, 1'b1, '{15'd5, CURV_MAX, 1'b1, 1'b1, 1'b0}},
    '{'{16'd12345, 11'd1024, 1'b1}, 1'b1, '{15'd0, 39'd0, 1'b0, 1'b0, 1'b1}},
    '{'{16'd1000, 11'd100, 1'b0}, 1'b0, '0},
    '{'{16'd1000, 11'd101, 1'b0}, 1'b0, '0},
    '{'{16'd1000, 11'd102, 1'b0}, 1'b0, '0},
    '{'{16'd1000, 11'd103, 1'b0}, 1'b0, '0},
    '{'{16'd1000, 11'd104, 1'b0}, 1'b0, '0},
    '{'{16'd1000, 11'd105, 1'b0}, 1'b0, '0},
    '{'{16'd1000, 11'd106, 1'b0}, 1'b0, '0},
    '{'{16'd5000, 11'd107, 1'b0}, 1'b0, '0},
    '{'{16'd5000, 11'd108, 1'b0}, 1'b0, '0},
    '{'{16'd5000, 11'd109, 1'b0}, 1'b0, '0},
    '{'{16'd1000, 11'd110, 1'b0}, 1'b0, '0},
    '{'{16'd1000, 11'd111, 1'b0}, 1'b0, '0},
    '{'{16'd1000, 11'd112, 1'b0}, 1'b0, '0},
    '{'{16'd1000, 11'd113, 1'b1}, 1'b0, '0}
  };

  logic      clk = 1'b0;
  logic      rst_n;
  logic      cfg_we;
  logic [1:0] cfg_idx;
  logic [15:0] cfg_wdata;
  logic      in_valid;
  logic      in_ready;
  scm_pkg::in_word_t  in_word;
  logic      out_valid;
  logic      out_ready;
  scm_pkg::out_word_t out_word;

  // Scoring model state: newest point at index 0 of each window.
  logic [15:0] rng_win [13];
  logic [10:0] col_win [13];
  logic        mrk_win [13];
  logic [14:0] next_idx;
  int unsigned pts_seen;
  int unsigned fwd_marks;
  logic [15:0] occ_gap;
  logic [9:0]  beam_q10;
  logic [10:0] col_lim;

  scm_pkg::out_word_t scores_due [$];
  int unsigned n_bad;
  int unsigned cyc_count = 0;
  int unsigned snd_calm;
  int unsigned rcv_calm;
  bit          fast_mode;
  bit          hold_ask;

  scan_curvature_and_occlusion_marker dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cyc_count <= cyc_count + 1;
    if (cyc_count == CYC_LIMIT) begin
      $display("tb_scan_curvature_and_occlusion_marker: done, errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Scoring model
  // ---------------------------------------------------------------------------

  function automatic void clear_scan();
    for (int k = 0; k < 13; k++) begin
      rng_win[k] = '0;
      col_win[k] = '0;
      mrk_win[k] = 1'b0;
    end
    next_idx  = '0;
    pts_seen  = 0;
    fwd_marks = 0;
  endfunction

  // Queue the result word of the point held at window slot j.
  function automatic void score_point(int j, logic [14:0] newest, bit ok, bit lst);
    longint             acc;
    longint unsigned    mag;
    scm_pkg::out_word_t o;
    o = '0;
    o.point_index = newest - 15'(j);
    if (ok && j >= 5 && j + 5 < 13) begin
      acc = 0;
      for (int k = j - 5; k <= j + 5; k++) begin
        if (k != j) acc += longint'(rng_win[k]);
      end
      acc -= 10 * longint'(rng_win[j]);
      mag = (acc < 0) ? longint'(-acc) : acc;
      o.curvature       = 39'(mag * mag);
      o.curvature_valid = 1'b1;
    end
    o.unreliable  = mrk_win[j];
    o.last_result = lst;
    scores_due.insert(scores_due.size(), o);
  endfunction

  // Advance the model by one accepted point and queue what it releases.
  function automatic void track_point(scm_pkg::in_word_t w);
    logic [14:0] newest;
    int          jtop;
    int          cd;
    int          r0, r1, r2;
    longint      lim, d1, d2;
    for (int k = 12; k > 0; k--) begin
      rng_win[k] = rng_win[k-1];
      col_win[k] = col_win[k-1];
      mrk_win[k] = mrk_win[k-1];
    end
    rng_win[0] = w.range_mm;
    col_win[0] = w.column;
    mrk_win[0] = (fwd_marks > 0);
    if (fwd_marks > 0) fwd_marks--;
    newest   = next_idx;
    next_idx = next_idx + 15'd1;
    if (pts_seen < 16) pts_seen++;

    // Pair of the two newest points and the beam test on the one before.
    if (pts_seen >= 7) begin
      r0 = int'(rng_win[0]);
      r1 = int'(rng_win[1]);
      r2 = int'(rng_win[2]);
      cd = int'(col_win[0]) - int'(col_win[1]);
      if (cd < 0) cd = -cd;
      if (cd < int'(col_lim)) begin
        if (r1 - r0 > int'(occ_gap)) begin
          for (int k = 1; k <= 6; k++) mrk_win[k] = 1'b1;
        end else if (r0 - r1 > int'(occ_gap)) begin
          mrk_win[0] = 1'b1;
          fwd_marks  = 5;
        end
      end
      lim = longint'(beam_q10) * longint'(r1);
      d1  = longint'((r2 > r1) ? r2 - r1 : r1 - r2) * 1024;
      d2  = longint'((r1 > r0) ? r1 - r0 : r0 - r1) * 1024;
      if (d1 > lim && d2 > lim) mrk_win[1] = 1'b1;
    end

    // The last point flushes everything still held.
    if (w.last_point) begin
      jtop = (pts_seen - 1 > 6) ? 6 : int'(pts_seen) - 1;
      for (int j = jtop; j >= 0; j--) begin
        score_point(j, newest, (pts_seen >= j + 6) && (j >= 5), j == 0);
      end
      clear_scan();
    end else if (pts_seen >= 7) begin
      score_point(6, newest, pts_seen >= 12, 1'b0);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------

  // Idle cycles before a word; calm stretches give back-to-back traffic.
  function automatic int unsigned draw_wait(ref int unsigned calm);
    if (fast_mode) return 0;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      calm = $urandom_range(20, 60);
      return 0;
    end
    return $urandom_range(0, 14);
  endfunction

  task automatic offer_point(scm_pkg::in_word_t w, output int unsigned first);
    int unsigned gap;
    gap = draw_wait(snd_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_ready !== 1'b1);
    first = scores_due.size();
    track_point(w);
  endtask

  // Wait for every due result, then let the pipeline settle.
  task automatic drain_scores();
    in_valid <= 1'b0;
    while (scores_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_regs(logic [15:0] occ, logic [9:0] beam, logic [10:0] col);
    cfg_we    <= 1'b1;
    cfg_idx   <= scm_pkg::REG_OCC_GAP;
    cfg_wdata <= occ;
    @(posedge clk);
    cfg_idx   <= scm_pkg::REG_BEAM_RATIO;
    cfg_wdata <= 16'(beam);
    @(posedge clk);
    cfg_idx   <= scm_pkg::REG_COL_GAP;
    cfg_wdata <= 16'(col);
    @(posedge clk);
    cfg_we    <= 1'b0;
    occ_gap  = occ;
    beam_q10 = beam;
    col_lim  = col;
  endtask

  // One scan: mostly a smooth profile with steps and column runs, sometimes
  // pure noise.
  task automatic run_scan(int unsigned len, bit noisy);
    int                r;
    int                c;
    int unsigned       first;
    scm_pkg::in_word_t w;
    r = $urandom_range(0, 65535);
    c = $urandom_range(0, 2047);
    for (int unsigned i = 0; i < len; i++) begin
      if (noisy || $urandom_range(0, 15) == 0) begin
        w.range_mm = 16'($urandom);
        w.column   = 11'($urandom);
      end else begin
        case ($urandom_range(0, 7))
          0: r += int'($urandom_range(0, 20000));
          1: r -= int'($urandom_range(0, 20000));
          default: r += int'($urandom_range(0, 120)) - 60;
        endcase
        if (r < 0) r = 0;
        if (r > 65535) r = 65535;
        if ($urandom_range(0, 9) == 0) c = $urandom_range(0, 2047);
        else c = (c + 1) % 2048;
        w.range_mm = 16'(r);
        w.column   = 11'(c);
      end
      w.last_point = (i == len - 1);
      offer_point(w, first);
    end
  endtask

  task automatic run_items(int unsigned budget);
    int unsigned sent;
    int unsigned len;
    sent = 0;
    while (sent < budget) begin
      case ($urandom_range(0, 9))
        0: len = $urandom_range(1, 6);
        1: len = $urandom_range(13, 90);
        default: len = $urandom_range(7, 30);
      endcase
      run_scan(len, $urandom_range(0, 4) == 0);
      sent += len;
    end
  endtask

  initial begin : stim
    int unsigned first;
    int          i;
    int          ph;
    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_idx   <= scm_pkg::REG_OCC_GAP;
    cfg_wdata <= '0;
    in_valid  <= 1'b0;
    in_word   <= '0;
    n_bad     = 0;
    snd_calm  = 0;
    fast_mode = 1'b0;
    hold_ask  = 1'b0;
    occ_gap   = scm_pkg::OCC_GAP_RST;
    beam_q10  = scm_pkg::BEAM_RATIO_RST;
    col_lim   = scm_pkg::COL_GAP_RST;
    clear_scan();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table under the reset settings.
    for (i = 0; i < DIR_ROWS; i++) begin
      offer_point(DIR_TAB[i].pt, first);
      if (DIR_TAB[i].typed) scores_due[first] = DIR_TAB[i].res;
    end
    drain_scores();

    // Random scans under a range of register settings.
    for (ph = 0; ph < 5; ph++) begin
      case (ph)
        0: set_regs(16'd0, 10'd0, CMAX);
        1: set_regs(RMAX, 10'h3FF, 11'd0);
        2: set_regs(16'($urandom_range(0, 2000)), 10'($urandom_range(0, 100)),
                    11'($urandom_range(1, 40)));
        3: set_regs(16'($urandom), 10'($urandom), 11'($urandom));
        default: set_regs(16'($urandom_range(100, 600)), 10'($urandom_range(5, 60)),
                          11'($urandom_range(2, 20)));
      endcase
      if (ph == 2) begin
        // Long result stall while points keep coming, so that the block fills.
        hold_ask = 1'b1;
        snd_calm = 200;
        run_scan(60, 1'b0);
      end
      run_items(40);
      drain_scores();
    end

    // One scan at full rate on both sides.
    set_regs(scm_pkg::OCC_GAP_RST, scm_pkg::BEAM_RATIO_RST, scm_pkg::COL_GAP_RST);
    fast_mode = 1'b1;
    run_scan(30, 1'b0);
    drain_scores();
    fast_mode = 1'b0;

    if (n_bad == 0) begin
      $display("tb_scan_curvature_and_occlusion_marker: done, clean");
    end else begin
      $display("tb_scan_curvature_and_occlusion_marker: done, errors");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver and checker
  // ---------------------------------------------------------------------------

  task automatic check_score(scm_pkg::out_word_t got);
    scm_pkg::out_word_t want;
    if (scores_due.size() == 0) begin
      $error("result word for point %0d with none due", got.point_index);
      n_bad++;
      return;
    end
    want = scores_due[0];
    scores_due.delete(0);
    if (got.point_index !== want.point_index) begin
      $error("point_index: expected %0d, got %0d", want.point_index, got.point_index);
      n_bad++;
    end
    if (got.curvature !== want.curvature) begin
      $error("curvature: expected %0d, got %0d", want.curvature, got.curvature);
      n_bad++;
    end
    if (got.curvature_valid !== want.curvature_valid) begin
      $error("curvature_valid: expected %0d, got %0d",
             want.curvature_valid, got.curvature_valid);
      n_bad++;
    end
    if (got.unreliable !== want.unreliable) begin
      $error("unreliable: expected %0d, got %0d", want.unreliable, got.unreliable);
      n_bad++;
    end
    if (got.last_result !== want.last_result) begin
      $error("last_result: expected %0d, got %0d", want.last_result, got.last_result);
      n_bad++;
    end
  endtask

  initial begin : result_side
    int unsigned hold;
    out_ready <= 1'b0;
    rcv_calm = 0;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_ask) begin
        hold_ask = 1'b0;
        hold     = LONG_HOLD;
      end else begin
        hold = draw_wait(rcv_calm);
      end
      if (hold > 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      check_score(out_word);
    end
  end

endmodule
